### rtl/core/ekdc_pkg.sv
`timescale 1ns / 1ps

package ekdc_pkg;

	// default cursor coordinate width
	localparam int COORD_BITS_DEF = 12;

	// configuration register indexes
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROWS = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_COLS = 1'd1;

	// screen size after reset
	localparam int ROWS_RESET = 24;
	localparam int COLS_RESET = 80;

	// input opcodes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// decoded key codes
	typedef enum logic [3:0] {
		KEY_PLAIN = 4'd0,
		KEY_ESC   = 4'd1,
		KEY_LEFT  = 4'd2,
		KEY_RIGHT = 4'd3,
		KEY_UP    = 4'd4,
		KEY_DOWN  = 4'd5,
		KEY_PGUP  = 4'd6,
		KEY_PGDN  = 4'd7,
		KEY_HOME  = 4'd8,
		KEY_END   = 4'd9,
		KEY_DEL   = 4'd10
	} key_code_t;

	// escape sequence parser state
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_SEQ   = 2'd2,
		PH_DIGIT = 2'd3
	} parse_phase_t;

	// key event handed from parser to cursor and output stage
	typedef struct packed {
		logic      ready;
		key_code_t code;
		logic [7:0] pch;
		logic      quit;
	} key_evt_t;

endpackage

### rtl/core/ekdc_if.sv
`timescale 1ns / 1ps

// terminal input channel
interface ekdc_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] in_byte;

	modport source (output valid, output opcode, output in_byte, input ready);
	modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

// decoded key and cursor channel
interface ekdc_out_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic                  key_ready;
	logic [3:0]            key_code;
	logic [7:0]            plain_char;
	logic                  quit;
	logic [COORD_BITS-1:0] col_now;
	logic [COORD_BITS-1:0] row_now;

	modport source (output valid, output key_ready, output key_code, output plain_char,
		output quit, output col_now, output row_now, input ready);
	modport sink (input valid, input key_ready, input key_code, input plain_char,
		input quit, input col_now, input row_now, output ready);
endinterface

### rtl/core/ekdc_parser.sv
`timescale 1ns / 1ps

module ekdc_parser import ekdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       opcode,
	input  logic [7:0] in_byte,
	output key_evt_t   key
);

	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_BRACK  = 8'h5b;
	localparam logic [7:0] CH_TILDE  = 8'h7e;
	localparam logic [7:0] CH_SS3    = 8'h4f;
	localparam logic [7:0] CH_CTRL_Q = 8'h71 & 8'h1f;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	parse_phase_t phase_q, phase_d;
	logic [7:0]   first_q, first_d;
	logic [7:0]   second_q, second_d;
	logic         is_digit;

	function automatic key_code_t letter_key(input logic [7:0] b);
		key_code_t k;
		case (b)
			8'h41:   k = KEY_UP;
			8'h42:   k = KEY_DOWN;
			8'h43:   k = KEY_RIGHT;
			8'h44:   k = KEY_LEFT;
			8'h48:   k = KEY_HOME;
			8'h46:   k = KEY_END;
			default: k = KEY_ESC;
		endcase
		return k;
	endfunction

	function automatic key_code_t tilde_key(input logic [7:0] d);
		key_code_t k;
		case (d)
			8'h31:   k = KEY_HOME;
			8'h33:   k = KEY_DEL;
			8'h34:   k = KEY_END;
			8'h35:   k = KEY_PGUP;
			8'h36:   k = KEY_PGDN;
			8'h37:   k = KEY_HOME;
			8'h38:   k = KEY_END;
			default: k = KEY_ESC;
		endcase
		return k;
	endfunction

	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

	// next state and sequence byte capture
	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		second_d = second_q;
		if (opcode == OP_TIMEOUT) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (in_byte == CH_ESC) phase_d = PH_ESC;
				end
				PH_ESC: begin
					first_d = in_byte;
					phase_d = PH_SEQ;
				end
				PH_SEQ: begin
					second_d = in_byte;
					phase_d  = (first_q == CH_BRACK && is_digit) ? PH_DIGIT : PH_IDLE;
				end
				PH_DIGIT: phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// key decode
	always_comb begin
		key = '{ready: 1'b0, code: KEY_PLAIN, pch: 8'h00, quit: 1'b0};
		if (opcode == OP_TIMEOUT) begin
			if (phase_q != PH_IDLE) begin
				key.ready = 1'b1;
				key.code  = KEY_ESC;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (in_byte != CH_ESC) begin
						key.ready = 1'b1;
						key.pch   = in_byte;
						key.quit  = (in_byte == CH_CTRL_Q);
					end
				end
				PH_ESC: key.ready = 1'b0;
				PH_SEQ: begin
					if (!(first_q == CH_BRACK && is_digit)) begin
						key.ready = 1'b1;
						if (first_q == CH_BRACK)
							key.code = letter_key(in_byte);
						else if (first_q == CH_SS3 && (in_byte == 8'h48 || in_byte == 8'h46))
							key.code = letter_key(in_byte);
						else
							key.code = KEY_ESC;
					end
				end
				PH_DIGIT: begin
					key.ready = 1'b1;
					key.code  = (in_byte == CH_TILDE) ? tilde_key(second_q) : KEY_ESC;
				end
				default: key.ready = 1'b0;
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			first_q  <= 8'h00;
			second_q <= 8'h00;
		end else if (step) begin
			phase_q  <= phase_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

endmodule

### rtl/core/ekdc_cursor.sv
`timescale 1ns / 1ps

module ekdc_cursor import ekdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  key_evt_t              key,
	input  logic [COORD_BITS-1:0] screen_rows,
	input  logic [COORD_BITS-1:0] screen_cols,
	output logic [COORD_BITS-1:0] col_next,
	output logic [COORD_BITS-1:0] row_next
);

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COORD_BITS-1:0] last_col, last_row;

	// a zero screen size counts as one
	assign last_col = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
	assign last_row = (screen_rows == '0) ? '0 : screen_rows - 1'b1;

	// clamped cursor move
	always_comb begin
		col_next = col_q;
		row_next = row_q;
		if (key.ready) begin
			case (key.code)
				KEY_LEFT:  if (col_q != '0) col_next = col_q - 1'b1;
				KEY_RIGHT: if (col_q < last_col) col_next = col_q + 1'b1;
				KEY_UP:    if (row_q != '0) row_next = row_q - 1'b1;
				KEY_DOWN:  if (row_q < last_row) row_next = row_q + 1'b1;
				KEY_HOME:  col_next = '0;
				KEY_END:   col_next = last_col;
				KEY_PGUP:  row_next = '0;
				KEY_PGDN:  row_next = last_row;
				default:   col_next = col_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

### rtl/core/escape_key_decoder_cursor_top.sv
`timescale 1ns / 1ps

// Terminal key decoder with a clamped text cursor.
// term: one transaction per received byte (opcode 0) or read timeout (opcode 1).
// cursor: exactly one transaction per term transaction, in order, carrying the
//   decoded key (key_ready high when a key completed) and the cursor position.
// ESC [ A/B/C/D/H/F, ESC [ 1/3/4/5/6/7/8 ~ and ESC O H/F are decoded; anything else
//   inside a sequence, or a timeout there, gives a plain escape key.
// Screen size is set through cfg_we/cfg_index/cfg_data: index 0 rows, 1 columns;
//   write only while no transaction is in flight.
// Path: a term transaction is held in one input register; the decode and cursor
//   update sit combinationally between it and one result register, which drives
//   the cursor channel.
// Throughput: one transaction per cycle while cursor.ready is high; the parser and
//   cursor registers are updated in the same cycle that a result is loaded.
// Reset: parser idle, cursor at row 0 column 0, screen 24 rows by 80 columns,
//   both channels empty.
// Stall: while cursor.ready is low the result holds; the input register still
//   takes one more transaction, then term.ready drops until the result moves.
module escape_key_decoder_cursor_top import ekdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ekdc_in_if.sink                 term,
	ekdc_out_if.source              cursor,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	logic                  v_s1, v_s2;
	logic                  opcode_s1;
	logic [7:0]            byte_s1;
	logic                  adv_s2, step;
	key_evt_t              key, key_s2;
	logic [COORD_BITS-1:0] rows_q, cols_q;
	logic [COORD_BITS-1:0] col_next, row_next, col_s2, row_s2;

	// handshake: result register frees, input register follows
	assign adv_s2     = !v_s2 || cursor.ready;
	assign term.ready = !v_s1 || adv_s2;
	assign step       = v_s1 && adv_s2;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= COORD_BITS'(ROWS_RESET);
			cols_q <= COORD_BITS'(COLS_RESET);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data;
			if (cfg_index == REG_COLS) cols_q <= cfg_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (term.ready) begin
			v_s1 <= term.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (term.valid && term.ready) begin
			opcode_s1 <= term.opcode;
			byte_s1   <= term.in_byte;
		end
	end

	ekdc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.opcode  (opcode_s1),
		.in_byte (byte_s1),
		.key     (key)
	);

	ekdc_cursor #(.COORD_BITS(COORD_BITS)) u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.key         (key),
		.screen_rows (rows_q),
		.screen_cols (cols_q),
		.col_next    (col_next),
		.row_next    (row_next)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			key_s2 <= key;
			col_s2 <= col_next;
			row_s2 <= row_next;
		end
	end

	assign cursor.valid      = v_s2;
	assign cursor.key_ready  = key_s2.ready;
	assign cursor.key_code   = key_s2.code;
	assign cursor.plain_char = key_s2.pch;
	assign cursor.quit       = key_s2.quit;
	assign cursor.col_now    = col_s2;
	assign cursor.row_now    = row_s2;

`ifndef SYNTHESIS
	// no key means every key field is clear
	a_no_key_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !key_s2.ready) |-> (key_s2.code == KEY_PLAIN && key_s2.pch == 8'h00
		&& !key_s2.quit))
		else $error("key fields set without a completed key");

	// quit only comes with a plain ctrl-q
	a_quit_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && key_s2.quit) |-> (key_s2.ready && key_s2.code == KEY_PLAIN
		&& key_s2.pch == 8'h11))
		else $error("quit flag without plain ctrl-q");

	// a stalled result keeps the input register occupied
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !cursor.ready) |=> v_s1)
		else $error("input register lost a transaction during stall");

	// an accepted transaction lands in the input register
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		(term.valid && term.ready) |=> v_s1)
		else $error("accepted transaction not held");
`endif

endmodule
